FILE: src/shbh_pkg.sv
// Shared types and constants of the SHA-256 byte stream hasher.
// Depends on nothing; every other file imports it.
package shbh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  // Index 0 holds working variable a (or chaining word 0), index 7 holds h.
  typedef logic [7:0][31:0] words_t;

  localparam words_t IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] round_const(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

FILE: src/shbh_round.sv
// One SHA-256 round and one message schedule step, shared by all 64 rounds.
// Depends on shbh_pkg.
module shbh_round
  import shbh_pkg::*;
(
  input  words_t        work,
  input  logic [511:0]  window,
  input  logic [5:0]    rnd,
  output words_t        work_next,
  output logic [31:0]   w_new
);

  logic [31:0] w0, w1, w9, w14;
  logic [31:0] s0, s1, bs0, bs1, ch, mj, t1;

  always_comb begin
    // Word i of the sliding window sits at bits 511-32*i.
    w0  = window[511:480];
    w1  = window[479:448];
    w9  = window[223:192];
    w14 = window[63:32];
    s0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
    s1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
    w_new = s1 + w9 + s0 + w0;

    bs1 = {work[4][5:0], work[4][31:6]} ^ {work[4][10:0], work[4][31:11]}
        ^ {work[4][24:0], work[4][31:25]};
    ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
    t1  = work[7] + bs1 + ch + round_const(rnd) + w0;
    bs0 = {work[0][1:0], work[0][31:2]} ^ {work[0][12:0], work[0][31:13]}
        ^ {work[0][21:0], work[0][31:22]};
    mj  = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);

    work_next[7] = work[6];
    work_next[6] = work[5];
    work_next[5] = work[4];
    work_next[4] = work[3] + t1;
    work_next[3] = work[2];
    work_next[2] = work[1];
    work_next[1] = work[0];
    work_next[0] = t1 + bs0 + mj;
  end

endmodule

FILE: src/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher.
// Depends on shbh_pkg and shbh_round.
//
// The block absorbs one message byte per input beat into a 512-bit shift
// register. When a block fills, the block drops ready while 64 rounds run
// through one shared round unit, one round per cycle, with the message
// schedule computed in the same shift register, and then folds the result
// into the chaining words. An end-of-message beat pads the block one byte
// per cycle (with a second padded block and compression when the length
// does not fit), runs the final compression, and then presents the eight
// digest words as eight output beats, word 0 first, last_word set on
// word 7. Input is not taken while the digest is being delivered; after
// the last word the chaining words return to the SHA-256 initial values
// and the length count clears. The length count wraps modulo 2^64 bits.
module sha256_byte_stream_hasher
  import shbh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_COMP, S_ADD, S_OUT} state_t;

  state_t       state_r;
  logic [511:0] buf_r;       // block bytes, then the schedule window
  words_t       chain_r;
  words_t       work_r;
  words_t       work_nxt;
  logic [31:0]  w_new;
  logic [5:0]   pos_r;       // bytes in the block buffer
  logic [5:0]   pos_nxt;
  logic [5:0]   rnd_r;
  logic [54:0]  blk_r;       // completed data blocks
  logic [63:0]  len_r;       // message length in bits, latched at finish
  logic         fin_r;       // message end requested
  logic         pad_r;       // padding has begun
  logic         final_r;     // the block being padded carries the length
  logic         first_r;     // next pad byte is the marker
  logic [2:0]   idx_r;
  logic [7:0]   pad_byte;

  shbh_round u_round (
    .work      (work_r),
    .window    (buf_r),
    .rnd       (rnd_r),
    .work_next (work_nxt),
    .w_new     (w_new)
  );

  assign pos_nxt = pos_r + {5'd0, in_data.byte_present};

  always_comb begin
    if (first_r) begin
      pad_byte = PAD_MARK;
    end else if (final_r && (pos_r >= 6'd56)) begin
      pad_byte = len_r[8'd63 - {2'b00, pos_r[2:0], 3'b000} -: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data.digest_word = chain_r[idx_r];
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = (idx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chain_r <= IV;
      pos_r   <= '0;
      rnd_r   <= '0;
      blk_r   <= '0;
      fin_r   <= 1'b0;
      pad_r   <= 1'b0;
      final_r <= 1'b0;
      first_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            fin_r <= in_data.end_of_message;
            pos_r <= pos_nxt;
            if (in_data.byte_present) begin
              buf_r <= {buf_r[503:0], in_data.data_byte};
            end
            if (in_data.byte_present && (pos_r == 6'd63)) begin
              state_r <= S_COMP;
              work_r  <= chain_r;
              rnd_r   <= '0;
            end else if (in_data.end_of_message) begin
              state_r <= S_PAD;
              pad_r   <= 1'b1;
              first_r <= 1'b1;
              final_r <= (pos_nxt < 6'd56);
              len_r   <= {blk_r, pos_nxt, 3'b000};
            end
          end
        end
        S_PAD: begin
          buf_r   <= {buf_r[503:0], pad_byte};
          first_r <= 1'b0;
          pos_r   <= pos_r + 6'd1;
          if (pos_r == 6'd63) begin
            state_r <= S_COMP;
            work_r  <= chain_r;
            rnd_r   <= '0;
          end
        end
        S_COMP: begin
          work_r <= work_nxt;
          buf_r  <= {buf_r[479:0], w_new};
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain_r[i] <= chain_r[i] + work_r[i];
          end
          if (!pad_r) begin
            blk_r <= blk_r + 55'd1;
          end
          if (!fin_r) begin
            state_r <= S_IDLE;
          end else if (!pad_r) begin
            // The finishing byte filled a block: pad a fresh one.
            state_r <= S_PAD;
            pad_r   <= 1'b1;
            first_r <= 1'b1;
            final_r <= 1'b1;
            len_r   <= {blk_r + 55'd1, 6'd0, 3'b000};
          end else if (!final_r) begin
            state_r <= S_PAD;
            final_r <= 1'b1;
          end else begin
            state_r <= S_OUT;
            idx_r   <= '0;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              state_r <= S_IDLE;
              chain_r <= IV;
              blk_r   <= '0;
              pos_r   <= '0;
              fin_r   <= 1'b0;
              pad_r   <= 1'b0;
              final_r <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/shbh_check.sv
// Port-level checker for the SHA-256 byte stream hasher, with its bind.
// Depends on shbh_pkg and the top level.
module shbh_check
  import shbh_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // No input is taken while digest words are pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest pending");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last_word does not match word 7");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_word) |=>
      (out_valid && (out_data.word_index == $past(out_data.word_index) + 3'd1)))
    else $error("digest words out of order");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_word) |=> (!out_valid && in_ready))
    else $error("block not idle after final digest word");

  a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_data.word_index == 3'd0))
    else $error("digest does not start at word 0");

endmodule

bind sha256_byte_stream_hasher shbh_check u_shbh_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
